/* src/tbc_pkg.sv */
// shared types, constants and helpers for the threshold blob centroid block
package tbc_pkg;

	localparam int RED_W       = 8;
	localparam int COORD_W     = 11;
	localparam int COUNT_W     = 23;
	localparam int SUM_W       = 34;
	localparam int LIMIT_W     = COORD_W + 2;
	localparam int REG_IDX_W   = 2;
	localparam int CFG_DATA_W  = COUNT_W;
	localparam int DIV_STEPS   = SUM_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RED_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BINARY_HIGH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_PIXELS    = 2'd2;

	// reset values of the registers
	localparam logic [RED_W-1:0]   RST_RED_THRESHOLD = 8'd200;
	localparam logic [RED_W-1:0]   RST_BINARY_HIGH   = 8'd255;
	localparam logic [COUNT_W-1:0] RST_MIN_PIXELS    = 23'd50;

	typedef struct packed {
		logic [RED_W-1:0]   red_threshold;
		logic [RED_W-1:0]   binary_high_value;
		logic [COUNT_W-1:0] min_pixels;
	} cfg_t;

	// one finished frame as handed from front to back
	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum_x;
		logic [SUM_W-1:0]   sum_y;
	} frame_rec_t;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] previous_x;
		logic [COORD_W-1:0] previous_y;
		logic               segment_ok;
		logic [COUNT_W-1:0] lit_count;
	} result_t;

	// clamp a quotient to the coordinate range
	function automatic logic [COORD_W-1:0] clamp_coord(input logic [SUM_W-1:0] q);
		return (|q[SUM_W-1:COORD_W]) ? COORD_MAX : q[COORD_W-1:0];
	endfunction

endpackage

/* src/threshold_blob_centroid.sv */
// top level of the threshold blob centroid block
// Takes one pixel per clock (push while full is low) and gives one result per
// frame, on the pixel marked frame_end. The front counts lit pixels and sums
// their columns and lines; at frame end it places the frame's totals in a
// two-entry queue and starts the next frame at once. The back takes frames
// from that queue: a frame not above the pixel minimum goes through load and
// write of the result register, a detected frame through load, 34 steps of a
// bit-serial divider run for x and y side by side, and write of the result
// register. full rises only while two finished frames wait in the queue.
// Results wait in a one-entry output register: empty low shows one, pop takes it.
// Registers are written with wr_en, wr_index and wr_data; write them only while
// the block is idle.
module threshold_blob_centroid #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [tbc_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [tbc_pkg::CFG_DATA_W-1:0]    wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic [tbc_pkg::RED_W-1:0]         red_level,
	input  logic [tbc_pkg::COORD_W-1:0]       column,
	input  logic [tbc_pkg::COORD_W-1:0]       line_index,
	input  logic                              frame_end,
	output logic                              empty,
	input  logic                              pop,
	output logic                              found,
	output logic [tbc_pkg::COORD_W-1:0]       center_x,
	output logic [tbc_pkg::COORD_W-1:0]       center_y,
	output logic [tbc_pkg::COORD_W-1:0]       previous_x,
	output logic [tbc_pkg::COORD_W-1:0]       previous_y,
	output logic                              segment_ok,
	output logic [tbc_pkg::COUNT_W-1:0]       lit_count
);

	tbc_pkg::cfg_t       cfg_q;
	tbc_pkg::frame_rec_t push_rec, head_rec;
	tbc_pkg::result_t    result;
	logic                rec_push, rec_pop, rec_empty, accept;

	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_threshold     <= tbc_pkg::RST_RED_THRESHOLD;
			cfg_q.binary_high_value <= tbc_pkg::RST_BINARY_HIGH;
			cfg_q.min_pixels        <= tbc_pkg::RST_MIN_PIXELS;
		end else if (wr_en) begin
			case (wr_index)
				tbc_pkg::REG_RED_THRESHOLD: begin
					cfg_q.red_threshold <= wr_data[tbc_pkg::RED_W-1:0];
				end
				tbc_pkg::REG_BINARY_HIGH: begin
					cfg_q.binary_high_value <= wr_data[tbc_pkg::RED_W-1:0];
				end
				tbc_pkg::REG_MIN_PIXELS: begin
					cfg_q.min_pixels <= wr_data[tbc_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tbc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.red_level  (red_level),
		.column     (column),
		.line_index (line_index),
		.frame_end  (frame_end),
		.rec_push   (rec_push),
		.rec        (push_rec)
	);

	tbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (push_rec),
		.pop       (rec_pop),
		.pop_data  (head_rec),
		.full      (full),
		.empty     (rec_empty)
	);

	tbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (rec_empty),
		.rec       (head_rec),
		.rec_pop   (rec_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	// result fields
	assign found      = result.found;
	assign center_x   = result.center_x;
	assign center_y   = result.center_y;
	assign previous_x = result.previous_x;
	assign previous_y = result.previous_y;
	assign segment_ok = result.segment_ok;
	assign lit_count  = result.lit_count;

endmodule

/* src/tbc_front.sv */
// front part: pixel classification and per-frame accumulation
module tbc_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tbc_pkg::cfg_t                  cfg,
	input  logic                           accept,
	input  logic [tbc_pkg::RED_W-1:0]      red_level,
	input  logic [tbc_pkg::COORD_W-1:0]    column,
	input  logic [tbc_pkg::COORD_W-1:0]    line_index,
	input  logic                           frame_end,
	output logic                           rec_push,
	output tbc_pkg::frame_rec_t            rec
);

	localparam logic [tbc_pkg::LIMIT_W-1:0] WIDTH_LIM  = tbc_pkg::LIMIT_W'(MAX_WIDTH);
	localparam logic [tbc_pkg::LIMIT_W-1:0] HEIGHT_LIM = tbc_pkg::LIMIT_W'(MAX_HEIGHT);

	logic [tbc_pkg::COUNT_W-1:0] count_q, count_nxt;
	logic [tbc_pkg::SUM_W-1:0]   sum_x_q, sum_x_nxt;
	logic [tbc_pkg::SUM_W-1:0]   sum_y_q, sum_y_nxt;
	logic [tbc_pkg::SUM_W:0]     sum_x_wide, sum_y_wide;
	logic                        in_frame, lit;

	// pixel is lit when bright enough, binary_high_value is nonzero and it is inside the frame
	always_comb begin
		in_frame = (tbc_pkg::LIMIT_W'(column) < WIDTH_LIM) &&
			(tbc_pkg::LIMIT_W'(line_index) < HEIGHT_LIM);
		lit = (red_level > cfg.red_threshold) && (cfg.binary_high_value != '0) && in_frame;
	end

	// saturating accumulation
	always_comb begin
		sum_x_wide = {1'b0, sum_x_q} + (tbc_pkg::SUM_W + 1)'(column);
		sum_y_wide = {1'b0, sum_y_q} + (tbc_pkg::SUM_W + 1)'(line_index);
		count_nxt  = count_q;
		sum_x_nxt  = sum_x_q;
		sum_y_nxt  = sum_y_q;
		if (lit) begin
			if (count_q != tbc_pkg::COUNT_MAX)
				count_nxt = count_q + 1'b1;
			sum_x_nxt = sum_x_wide[tbc_pkg::SUM_W] ? tbc_pkg::SUM_MAX :
				sum_x_wide[tbc_pkg::SUM_W-1:0];
			sum_y_nxt = sum_y_wide[tbc_pkg::SUM_W] ? tbc_pkg::SUM_MAX :
				sum_y_wide[tbc_pkg::SUM_W-1:0];
		end
	end

	// frame record including the last pixel
	always_comb begin
		rec_push    = accept && frame_end;
		rec.found   = count_nxt > cfg.min_pixels;
		rec.count   = count_nxt;
		rec.sum_x   = sum_x_nxt;
		rec.sum_y   = sum_y_nxt;
	end

	// accumulators, cleared after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				count_q <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else begin
				count_q <= count_nxt;
				sum_x_q <= sum_x_nxt;
				sum_y_q <= sum_y_nxt;
			end
		end
	end

endmodule

/* src/tbc_queue.sv */
// short queue of frame records between front and back
module tbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tbc_pkg::frame_rec_t push_data,
	input  logic                pop,
	output tbc_pkg::frame_rec_t pop_data,
	output logic                full,
	output logic                empty
);

	localparam logic [tbc_pkg::QPTR_W:0] DEPTH = (tbc_pkg::QPTR_W + 1)'(tbc_pkg::QUEUE_DEPTH);

	tbc_pkg::frame_rec_t          entry_q [tbc_pkg::QUEUE_DEPTH];
	logic [tbc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [tbc_pkg::QPTR_W:0]     fill_q;
	logic                         do_push, do_pop;

	assign full     = (fill_q == DEPTH);
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

/* src/tbc_back.sv */
// back part: centroid division, centroid history and result register
module tbc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_empty,
	input  tbc_pkg::frame_rec_t rec,
	output logic                rec_pop,
	input  logic                pop,
	output logic                empty,
	output tbc_pkg::result_t    result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	logic                          out_valid_q;
	logic                          had_prev_q;
	logic [tbc_pkg::COORD_W-1:0]   cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [tbc_pkg::STEP_W-1:0]    step_q;

	logic                          found_q;
	logic [tbc_pkg::COUNT_W-1:0]   count_q;
	logic [tbc_pkg::SUM_W-1:0]     quo_x_q, quo_y_q;
	logic [tbc_pkg::COUNT_W-1:0]   rem_x_q, rem_y_q;

	logic [tbc_pkg::COUNT_W:0]     rsh_x, rsh_y, diff_x, diff_y;
	logic                          ge_x, ge_y;
	logic                          out_free, emit;
	logic [tbc_pkg::COORD_W-1:0]   new_x, new_y;

	assign rec_pop  = (state_q == ST_IDLE) && !rec_empty;
	assign out_free = !out_valid_q || pop;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign empty    = !out_valid_q;
	assign new_x    = tbc_pkg::clamp_coord(quo_x_q);
	assign new_y    = tbc_pkg::clamp_coord(quo_y_q);

	// one restoring division step per cycle for each axis
	always_comb begin
		rsh_x  = {rem_x_q, quo_x_q[tbc_pkg::SUM_W-1]};
		rsh_y  = {rem_y_q, quo_y_q[tbc_pkg::SUM_W-1]};
		diff_x = rsh_x - {1'b0, count_q};
		diff_y = rsh_y - {1'b0, count_q};
		ge_x   = rsh_x >= {1'b0, count_q};
		ge_y   = rsh_y >= {1'b0, count_q};
	end

	// sequencer, centroid history and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			had_prev_q  <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			// result register fills on emit and drains on pop
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!rec_empty)
						state_q <= rec.found ? ST_DIVIDE : ST_EMIT;
				end
				ST_DIVIDE: begin
					step_q <= step_q + 1'b1;
					if (step_q == tbc_pkg::STEP_W'(tbc_pkg::DIV_STEPS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (found_q) begin
							prev_x_q   <= cur_x_q;
							prev_y_q   <= cur_y_q;
							cur_x_q    <= new_x;
							cur_y_q    <= new_y;
							had_prev_q <= 1'b1;
						end else begin
							had_prev_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// division datapath and result payload
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			found_q <= rec.found;
			count_q <= rec.count;
			quo_x_q <= rec.sum_x;
			quo_y_q <= rec.sum_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			quo_x_q <= {quo_x_q[tbc_pkg::SUM_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[tbc_pkg::SUM_W-2:0], ge_y};
			rem_x_q <= ge_x ? diff_x[tbc_pkg::COUNT_W-1:0] : rsh_x[tbc_pkg::COUNT_W-1:0];
			rem_y_q <= ge_y ? diff_y[tbc_pkg::COUNT_W-1:0] : rsh_y[tbc_pkg::COUNT_W-1:0];
		end
		if (emit) begin
			result.found     <= found_q;
			result.lit_count <= count_q;
			if (found_q) begin
				result.center_x   <= new_x;
				result.center_y   <= new_y;
				result.previous_x <= cur_x_q;
				result.previous_y <= cur_y_q;
				result.segment_ok <= had_prev_q;
			end else begin
				result.center_x   <= cur_x_q;
				result.center_y   <= cur_y_q;
				result.previous_x <= prev_x_q;
				result.previous_y <= prev_y_q;
				result.segment_ok <= 1'b0;
			end
		end
	end

endmodule

/* src/tbc_checker.sv */
// port-level checks for the threshold blob centroid block, bound to the top level
module tbc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic                              found,
	input logic [tbc_pkg::COORD_W-1:0]       center_x,
	input logic [tbc_pkg::COORD_W-1:0]       center_y,
	input logic [tbc_pkg::COORD_W-1:0]       previous_x,
	input logic [tbc_pkg::COORD_W-1:0]       previous_y,
	input logic                              segment_ok,
	input logic [tbc_pkg::COUNT_W-1:0]       lit_count
);

	// continuity flag only with a detection
	a_seg_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && segment_ok |-> found)
		else $error("segment_ok without found");

	// a detection always has lit pixels
	a_found_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && found |-> lit_count != '0)
		else $error("found with zero lit_count");

	// a waiting result holds until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(found) && $stable(center_x) &&
		$stable(center_y) && $stable(previous_x) && $stable(previous_y) &&
		$stable(segment_ok) && $stable(lit_count))
		else $error("waiting result changed");

endmodule

bind threshold_blob_centroid tbc_checker u_tbc_checker (.*);
